/* design/sobs_pkg.sv */
// shared constants and command codes for the segment/obstacle intersection block
package sobs_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_COORD_BITS   = 16;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

endpackage

/* design/sobs_if.sv */
// valid/ready channel interfaces for command items and result items
interface sobs_in_if #(
  parameter int COORD_BITS = sobs_pkg::DEF_COORD_BITS
);
  logic                          valid;
  logic                          ready;
  logic [sobs_pkg::CMD_W-1:0]    cmd;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic                          closes_polygon;

  modport source (
    output valid, cmd, point_x, point_y, end_x, end_y, closes_polygon,
    input  ready
  );
  modport sink (
    input  valid, cmd, point_x, point_y, end_x, end_y, closes_polygon,
    output ready
  );
endinterface

interface sobs_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic table_overflow;

  modport source (output valid, hit, table_overflow, input ready);
  modport sink (input valid, hit, table_overflow, output ready);
endinterface

/* design/sobs_vtab.sv */
// vertex table: synchronous memory with one write port and one read port, registered read data
module sobs_vtab #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 33
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/sobs_edge_test.sv */
// pipelined segment/segment meet test: edge register, products, sign decision
module sobs_edge_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] p1x,
  input  logic signed [COORD_BITS-1:0] p1y,
  input  logic signed [COORD_BITS-1:0] p2x,
  input  logic signed [COORD_BITS-1:0] p2y,
  input  logic signed [COORD_BITS-1:0] q1x,
  input  logic signed [COORD_BITS-1:0] q1y,
  input  logic signed [COORD_BITS-1:0] q2x,
  input  logic signed [COORD_BITS-1:0] q2y,
  output logic                         meet_vld,
  output logic                         meet
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int OW = PW + 1;

  // stage 1: edge and query endpoints
  logic                 s1_vld_r;
  logic signed [CB-1:0] a1x_r, a1y_r, a2x_r, a2y_r;
  logic signed [CB-1:0] b1x_r, b1y_r, b2x_r, b2y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a1x_r <= p1x; a1y_r <= p1y; a2x_r <= p2x; a2y_r <= p2y;
    b1x_r <= q1x; b1y_r <= q1y; b2x_r <= q2x; b2y_r <= q2y;
  end

  // differences, sign-extended one bit
  function automatic logic signed [DW-1:0] sdiff(input logic signed [CB-1:0] u,
                                                 input logic signed [CB-1:0] v);
    sdiff = $signed({u[CB-1], u}) - $signed({v[CB-1], v});
  endfunction

  // p within bounding box of segment u-v
  function automatic logic in_box(input logic signed [CB-1:0] px,
                                  input logic signed [CB-1:0] py,
                                  input logic signed [CB-1:0] ux,
                                  input logic signed [CB-1:0] uy,
                                  input logic signed [CB-1:0] vx,
                                  input logic signed [CB-1:0] vy);
    in_box = (ux <= px || vx <= px) && (px <= ux || px <= vx) &&
             (uy <= py || vy <= py) && (py <= uy || py <= vy);
  endfunction

  logic signed [DW-1:0] qdx, qdy, pdx, pdy;
  logic signed [DW-1:0] e1x, e1y, e2x, e2y, f1x, f1y, f2x, f2y;

  assign qdx = sdiff(b2x_r, b1x_r);
  assign qdy = sdiff(b2y_r, b1y_r);
  assign pdx = sdiff(a2x_r, a1x_r);
  assign pdy = sdiff(a2y_r, a1y_r);
  assign e1x = sdiff(a1x_r, b1x_r);
  assign e1y = sdiff(a1y_r, b1y_r);
  assign e2x = sdiff(a2x_r, b1x_r);
  assign e2y = sdiff(a2y_r, b1y_r);
  assign f1x = sdiff(b1x_r, a1x_r);
  assign f1y = sdiff(b1y_r, a1y_r);
  assign f2x = sdiff(b2x_r, a1x_r);
  assign f2y = sdiff(b2y_r, a1y_r);

  // stage 2: eight products and four box tests
  logic                 s2_vld_r;
  logic signed [PW-1:0] m1a_r, m1b_r, m2a_r, m2b_r, m3a_r, m3b_r, m4a_r, m4b_r;
  logic                 bx1_r, bx2_r, bx3_r, bx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m1a_r <= PW'(qdx) * PW'(e1y);
    m1b_r <= PW'(qdy) * PW'(e1x);
    m2a_r <= PW'(qdx) * PW'(e2y);
    m2b_r <= PW'(qdy) * PW'(e2x);
    m3a_r <= PW'(pdx) * PW'(f1y);
    m3b_r <= PW'(pdy) * PW'(f1x);
    m4a_r <= PW'(pdx) * PW'(f2y);
    m4b_r <= PW'(pdy) * PW'(f2x);
    bx1_r <= in_box(a1x_r, a1y_r, b1x_r, b1y_r, b2x_r, b2y_r);
    bx2_r <= in_box(a2x_r, a2y_r, b1x_r, b1y_r, b2x_r, b2y_r);
    bx3_r <= in_box(b1x_r, b1y_r, a1x_r, a1y_r, a2x_r, a2y_r);
    bx4_r <= in_box(b2x_r, b2y_r, a1x_r, a1y_r, a2x_r, a2y_r);
  end

  // final: orientations and decision
  logic signed [OW-1:0] d1, d2, d3, d4;
  logic                 z1, z2, z3, z4;
  logic                 n1, n2, n3, n4;
  logic                 crosses;

  assign d1 = $signed({m1a_r[PW-1], m1a_r}) - $signed({m1b_r[PW-1], m1b_r});
  assign d2 = $signed({m2a_r[PW-1], m2a_r}) - $signed({m2b_r[PW-1], m2b_r});
  assign d3 = $signed({m3a_r[PW-1], m3a_r}) - $signed({m3b_r[PW-1], m3b_r});
  assign d4 = $signed({m4a_r[PW-1], m4a_r}) - $signed({m4b_r[PW-1], m4b_r});

  assign z1 = (d1 == '0);
  assign z2 = (d2 == '0);
  assign z3 = (d3 == '0);
  assign z4 = (d4 == '0);
  assign n1 = d1[OW-1];
  assign n2 = d2[OW-1];
  assign n3 = d3[OW-1];
  assign n4 = d4[OW-1];

  // strict sign change on both pairs
  assign crosses = !z1 && !z2 && (n1 != n2) && !z3 && !z4 && (n3 != n4);

  assign meet_vld = s2_vld_r;
  assign meet     = crosses || (z1 && bx1_r) || (z2 && bx2_r) ||
                    (z3 && bx3_r) || (z4 && bx4_r);

endmodule

/* design/segment_obstacle_intersection.sv */
// top level: command decode, vertex table walk sequencer and result register
//
// Usage
//   in_ch carries command items: clear table, append vertex, or query segment.
//   out_ch carries one result item per query (hit, sticky table_overflow);
//   clear and append items, and the unused command code, give no result.
//   A query walks the stored vertices from the vertex table, one edge per
//   cycle, through the single read port of the table, then drains the edge
//   pipeline and loads its result into the output register.
//   One item is handled at a time; in_ch.ready is high whenever no query is
//   in progress.
//   The output register parts the two sides: clears and appends are still
//   taken while a result waits. If the receiver stalls, a finishing query
//   holds in its last cycle until the output register is free.
//   Reset (rst_n low, synchronous) empties the table and clears the overflow
//   flag and the output register. Table contents are never cleared; only
//   entries below the vertex count are ever read.
module segment_obstacle_intersection #(
  parameter int MAX_VERTICES = sobs_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = sobs_pkg::DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  sobs_in_if.sink   in_ch,
  sobs_out_if.source out_ch
);

  import sobs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int VW = 2 * CB + 1;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VERTICES);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;  // issue table reads
  localparam logic [2:0] ST_TAIL  = 3'd2;  // closing edge of the last polygon
  localparam logic [2:0] ST_DRAIN = 3'd3;  // let the edge pipeline empty
  localparam logic [2:0] ST_FIN   = 3'd4;  // load result register

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          drain_r, drain_nxt;
  logic          rvld_r;

  logic          accept;
  logic          do_append;
  logic          rd_en;
  logic          fin_load;

  // query segment held for the walk
  logic signed [CB-1:0] qx1_r, qy1_r, qx2_r, qy2_r;

  // previous vertex and first vertex of the current polygon
  logic signed [CB-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;
  logic                 prev_c_r;
  logic                 have_prev_r;

  logic                 hit_r;
  logic                 out_valid_r, out_hit_r, out_ovf_r;

  // table read data
  logic [VW-1:0]        rdata;
  logic signed [CB-1:0] v_x, v_y;
  logic                 v_c;

  // edge handed to the tester
  logic                 e_vld;
  logic signed [CB-1:0] e_bx, e_by;
  logic                 meet_vld, meet;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign do_append   = accept && (in_ch.cmd == CMD_APPEND) && (count_r < COUNT_MAX);
  assign rd_en       = (state_r == ST_WALK) && (rd_idx_r < count_r);
  assign fin_load    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // vertex word: closes mark, y, x
  sobs_vtab #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (VW)
  ) u_vtab (
    .clk   (clk),
    .we    (do_append),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_ch.closes_polygon, in_ch.point_y, in_ch.point_x}),
    .re    (rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  assign v_x = $signed(rdata[CB-1:0]);
  assign v_y = $signed(rdata[2*CB-1:CB]);
  assign v_c = rdata[2*CB];

  // sequencer and table bookkeeping
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    rd_idx_nxt = rd_idx_r;
    drain_nxt  = drain_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            CMD_APPEND: begin
              if (count_r < COUNT_MAX) begin
                count_nxt = count_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_QUERY: begin
              rd_idx_nxt = '0;
              state_nxt  = ST_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        drain_nxt = 1'b0;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_idx_r <= '0;
      drain_r  <= 1'b0;
      rvld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      rd_idx_r <= rd_idx_nxt;
      drain_r  <= drain_nxt;
      rvld_r   <= rd_en;
    end
  end

  // latch the query segment
  always_ff @(posedge clk) begin
    if (accept && in_ch.cmd == CMD_QUERY) begin
      qx1_r <= in_ch.point_x;
      qy1_r <= in_ch.point_y;
      qx2_r <= in_ch.end_x;
      qy2_r <= in_ch.end_y;
    end
  end

  // edge selection: each arriving vertex closes the edge of the one before;
  // a marked vertex instead closes back to its polygon's first vertex, and
  // the tail cycle closes the last polygon, marked or not
  always_comb begin
    if (state_r == ST_TAIL) begin
      e_vld = have_prev_r;
      e_bx  = start_x_r;
      e_by  = start_y_r;
    end else begin
      e_vld = rvld_r && have_prev_r;
      e_bx  = prev_c_r ? start_x_r : v_x;
      e_by  = prev_c_r ? start_y_r : v_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (accept) begin
      have_prev_r <= 1'b0;
    end else if (rvld_r) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rvld_r) begin
      prev_x_r <= v_x;
      prev_y_r <= v_y;
      prev_c_r <= v_c;
      // new polygon opens on the first vertex or after a marked one
      if (!have_prev_r || prev_c_r) begin
        start_x_r <= v_x;
        start_y_r <= v_y;
      end
    end
  end

  sobs_edge_test #(
    .COORD_BITS (CB)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e_vld),
    .p1x      (qx1_r),
    .p1y      (qy1_r),
    .p2x      (qx2_r),
    .p2y      (qy2_r),
    .q1x      (prev_x_r),
    .q1y      (prev_y_r),
    .q2x      (e_bx),
    .q2y      (e_by),
    .meet_vld (meet_vld),
    .meet     (meet)
  );

  // hit accumulates over all edges of the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (accept) begin
      hit_r <= 1'b0;
    end else if (meet_vld && meet) begin
      hit_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_hit_r <= hit_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.table_overflow = out_ovf_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("vertex count beyond table depth");

  a_table_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(count_r) && $stable(ovf_r))
    else $error("table changed during a query walk");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the final step");

  a_meet_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    meet_vld |-> (state_r == ST_WALK || state_r == ST_TAIL || state_r == ST_DRAIN))
    else $error("edge result arrived after the drain");
`endif

endmodule
